// ===== rtl/tarpd_pkg.sv =====
// Shared types and constants for the three-axis rate PD controller.
`default_nettype none
package tarpd_pkg;

  // Register reset values and register indexes
  localparam logic [23:0] PROP_GAIN_RST  = 24'd3277;
  localparam logic [23:0] DERIV_GAIN_RST = 24'd6554;
  localparam logic [22:0] TGT_MAG_RST    = 23'd9151;
  localparam logic [1:0]  REG_PROP_GAIN  = 2'd0;
  localparam logic [1:0]  REG_DERIV_GAIN = 2'd1;
  localparam logic [1:0]  REG_TGT_MAG    = 2'd2;

  // Divider and square root sizes
  localparam int DivNumW = 72;
  localparam int DivDenW = 40;
  localparam int SqrtInW = 64;
  localparam int SqrtOutW = SqrtInW / 2;

  // Microseconds per second and derivative magnitude limit
  localparam logic [31:0] MICRO_PER_SEC = 32'd1000000;
  localparam logic [71:0] D_LIMIT       = 72'd1 << 40;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQ_ACC,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_DES_MUL,
    ST_DES_DIV,
    ST_DES_WAIT,
    ST_P_MUL,
    ST_P_ACC,
    ST_D_MUL,
    ST_D_A,
    ST_D_M1,
    ST_D_M2,
    ST_D_M3,
    ST_D_WAIT,
    ST_AX_END,
    ST_FIN
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/three_axis_rate_pd_controller.sv =====
// Top level: sequencer, shared multiplier and datapath of the rate PD controller.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tdata: rates, pointing errors, step_us; tuser: is_first
//  out_    | out | out_tvalid/tready  | tdata: accel x, y, z
//  cfg_    | in  | cfg_wr_en          | cfg_index, cfg_wdata
//
// An item runs a square root, then per axis up to two passes through the shared
// divider plus a few multiply steps.
// A zero step_us transfer is consumed while idle, with no result.
// Reset clears the gains to their defaults and the stored rate errors to zero.
// in_tready is high only while the sequencer is idle; a held result stalls
// the final step until out_tready takes it.
`default_nettype none
module three_axis_rate_pd_controller (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // rate_x, rate_y, rate_z, point_err_x, point_err_y, point_err_z, step_us, pad
  input  wire logic [167:0] in_tdata,
  // is_first
  input  wire logic [0:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // accel_x, accel_y, accel_z
  output logic [95:0]       out_tdata,
  input  wire logic         cfg_wr_en,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [23:0]  cfg_wdata
);
  import tarpd_pkg::*;

  state_t state_r, state_nxt;

  logic [23:0] prop_gain_r, deriv_gain_r;
  logic [22:0] tgt_mag_r;

  logic signed [23:0] w_r   [3];
  logic        [23:0] emag_r[3];
  logic               eneg_r[3];
  logic signed [25:0] prev_r[3];
  logic signed [31:0] res_r [3];
  logic [19:0]        dt_r;
  logic               first_r;
  logic [1:0]         ax_r;
  logic [47:0]        s_r;
  logic [31:0]        n_r;
  logic signed [25:0] rr_r;
  logic [33:0]        pm_r;
  logic [49:0]        a_r;
  logic               dneg_r;
  logic [51:0]        lo_r;
  logic [63:0]        mul_r;
  logic               out_valid_r;
  logic [95:0]        out_data_r;

  // Shared multiplier operands and unit controls
  logic [31:0] mul_a, mul_b;
  logic        sqrt_start, div_start;
  logic [DivNumW-1:0] div_num;
  logic        div_busy, div_done, sqrt_done;
  logic [DivNumW-1:0] div_q;
  logic [SqrtOutW-1:0] sqrt_root;

  logic [25:0]        rmag;
  logic signed [26:0] dval;
  logic [25:0]        dmag;
  logic [23:0]        in_emag[3];
  logic signed [25:0] des;
  logic [40:0]        dm;
  logic signed [42:0] psum, nsum;
  logic signed [31:0] sat;
  logic               in_xfer;

  assign in_xfer = in_tvalid && in_tready;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_emag[i] = in_tdata[72+24*i+23] ? (24'd0 - in_tdata[72+24*i +: 24])
                                         : in_tdata[72+24*i +: 24];
    end
    rmag = rr_r[25] ? (26'd0 - 26'(rr_r)) : 26'(rr_r);
    dval = 27'(rr_r) - 27'(prev_r[ax_r]);
    dmag = dval[26] ? 26'(27'd0 - 27'(dval)) : 26'(dval);
    des  = eneg_r[ax_r] ? (26'd0 - {2'b00, div_q[23:0]}) : {2'b00, div_q[23:0]};
    dm   = (div_q > D_LIMIT) ? D_LIMIT[40:0] : div_q[40:0];
    psum = (rr_r[25] ? (43'd0 - 43'(pm_r)) : 43'(pm_r))
         + (dneg_r ? (43'd0 - 43'(dm)) : 43'(dm));
    nsum = 43'd0 - psum;
    if (nsum > 43'sd2147483647)        sat = 32'h7FFF_FFFF;
    else if (nsum < -43'sd2147483648)  sat = 32'h8000_0000;
    else                               sat = nsum[31:0];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_xfer && (in_tdata[163:144] != 20'd0)) state_nxt = ST_SQ;
      ST_SQ:        state_nxt = ST_SQ_ACC;
      ST_SQ_ACC:    state_nxt = (ax_r == 2'd2) ? ST_SQRT_GO : ST_SQ;
      ST_SQRT_GO:   state_nxt = ST_SQRT_WAIT;
      ST_SQRT_WAIT: if (sqrt_done) state_nxt = ST_DES_MUL;
      ST_DES_MUL:   state_nxt = ST_DES_DIV;
      ST_DES_DIV: begin
        if (n_r != 32'd0)  state_nxt = ST_DES_WAIT;
        else if (first_r)  state_nxt = ST_AX_END;
        else               state_nxt = ST_P_MUL;
      end
      ST_DES_WAIT:  if (div_done) state_nxt = first_r ? ST_AX_END : ST_P_MUL;
      ST_P_MUL:     state_nxt = ST_P_ACC;
      ST_P_ACC:     state_nxt = ST_D_MUL;
      ST_D_MUL:     state_nxt = ST_D_A;
      ST_D_A:       state_nxt = ST_D_M1;
      ST_D_M1:      state_nxt = ST_D_M2;
      ST_D_M2:      state_nxt = ST_D_M3;
      ST_D_M3:      state_nxt = ST_D_WAIT;
      ST_D_WAIT:    if (div_done) state_nxt = ST_AX_END;
      ST_AX_END:    state_nxt = (ax_r == 2'd2) ? ST_FIN : ST_DES_MUL;
      ST_FIN:       if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    div_num    = '0;
    in_tready  = (state_r == ST_IDLE);
    unique case (state_r)
      ST_SQ: begin
        mul_a = 32'(emag_r[ax_r]);
        mul_b = 32'(emag_r[ax_r]);
      end
      ST_SQRT_GO: sqrt_start = 1'b1;
      ST_DES_MUL: begin
        mul_a = 32'(tgt_mag_r);
        mul_b = 32'(emag_r[ax_r]);
      end
      ST_DES_DIV: begin
        div_start = (n_r != 32'd0);
        div_num   = {18'd0, mul_r[45:0], 8'd0} + 72'(n_r >> 1);
      end
      ST_P_MUL: begin
        mul_a = 32'(rmag);
        mul_b = 32'(prop_gain_r);
      end
      ST_D_MUL: begin
        mul_a = 32'(dmag);
        mul_b = 32'(deriv_gain_r);
      end
      ST_D_M1: begin
        mul_a = a_r[31:0];
        mul_b = MICRO_PER_SEC;
      end
      ST_D_M2: begin
        mul_a = 32'(a_r[49:32]);
        mul_b = MICRO_PER_SEC;
      end
      ST_D_M3: begin
        div_start = 1'b1;
        div_num   = {mul_r[39:0], 32'd0} + 72'(lo_r) + 72'({dt_r, 15'd0});
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ax_r         <= 2'd0;
      out_valid_r  <= 1'b0;
      prop_gain_r  <= PROP_GAIN_RST;
      deriv_gain_r <= DERIV_GAIN_RST;
      tgt_mag_r    <= TGT_MAG_RST;
      for (int i = 0; i < 3; i++) prev_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_PROP_GAIN:  prop_gain_r  <= cfg_wdata;
          REG_DERIV_GAIN: deriv_gain_r <= cfg_wdata;
          REG_TGT_MAG:    tgt_mag_r    <= cfg_wdata[22:0];
          default: ;
        endcase
      end
      if (state_r == ST_SQ_ACC || state_r == ST_AX_END) begin
        ax_r <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
      end
      if (state_r == ST_AX_END) prev_r[ax_r] <= rr_r;
      if (state_r == ST_FIN && (!out_valid_r || out_tready)) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
    if (in_xfer) begin
      for (int i = 0; i < 3; i++) begin
        w_r[i]    <= in_tdata[24*i +: 24];
        emag_r[i] <= in_emag[i];
        eneg_r[i] <= in_tdata[72+24*i+23];
      end
      dt_r    <= in_tdata[163:144];
      first_r <= in_tuser[0];
      s_r     <= '0;
    end
    unique case (state_r)
      ST_SQ_ACC:   s_r <= s_r + mul_r[47:0];
      ST_SQRT_WAIT: if (sqrt_done) n_r <= sqrt_root;
      ST_DES_DIV:  if (n_r == 32'd0) rr_r <= 26'(w_r[ax_r]);
      ST_DES_WAIT: if (div_done) rr_r <= 26'(w_r[ax_r]) + des;
      ST_P_ACC:    pm_r <= 34'((mul_r[48:0] + 49'd32768) >> 16);
      ST_D_MUL:    dneg_r <= dval[26];
      ST_D_A:      a_r <= mul_r[49:0];
      ST_D_M2:     lo_r <= mul_r[51:0];
      ST_D_WAIT:   if (div_done) res_r[ax_r] <= sat;
      ST_AX_END:   if (first_r) res_r[ax_r] <= '0;
      ST_FIN: begin
        if (!out_valid_r || out_tready) out_data_r <= {res_r[2], res_r[1], res_r[0]};
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  tarpd_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand ({s_r, 16'd0}),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  tarpd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  ((state_r == ST_D_M3) ? 40'({dt_r, 16'd0}) : 40'(n_r)),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Checks
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_out_low_after_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("result valid right after reset");
  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_tvalid && !out_tready) |=> state_r == ST_FIN)
    else $error("final step overwrote a held result");
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready) else $error("ready while sequencing");

endmodule
`default_nettype wire

// ===== rtl/tarpd_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module tarpd_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [tarpd_pkg::DivNumW-1:0] dividend,
  input  wire logic [tarpd_pkg::DivDenW-1:0] divisor,
  output logic                              busy,
  output logic                              done,
  output logic [tarpd_pkg::DivNumW-1:0]     quotient
);
  import tarpd_pkg::*;

  localparam int CntW = $clog2(DivNumW + 1);

  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic [DivDenW:0]   rem_r, rem_nxt;
  logic [DivNumW-1:0] quo_r, quo_nxt;
  logic [DivDenW-1:0] den_r;
  logic               done_r, done_nxt;
  logic [DivDenW:0]   rem_sh;
  logic               fits;

  // One shift-subtract step
  always_comb begin
    rem_sh   = {rem_r[DivDenW-1:0], quo_r[DivNumW-1]};
    fits     = (rem_sh >= {1'b0, den_r});
    rem_nxt  = fits ? (rem_sh - {1'b0, den_r}) : rem_sh;
    quo_nxt  = {quo_r[DivNumW-2:0], fits};
    cnt_nxt  = cnt_r - CntW'(1);
    done_nxt = (cnt_r == CntW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CntW'(DivNumW);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end else begin
      done_r <= 1'b0;
    end
  end

  // Operand registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy     = (cnt_r != '0);
  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== rtl/tarpd_sqrt.sv =====
// Integer square root, one result bit per cycle.
`default_nettype none
module tarpd_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [tarpd_pkg::SqrtInW-1:0]  radicand,
  output logic                               done,
  output logic [tarpd_pkg::SqrtOutW-1:0]     root
);
  import tarpd_pkg::*;

  localparam int CntW = $clog2(SqrtOutW + 1);

  logic [CntW-1:0]     cnt_r;
  logic                done_r;
  logic [SqrtInW-1:0]  x_r;
  logic [SqrtOutW+1:0] rem_r, rem_nxt, rem_sh, trial;
  logic [SqrtOutW-1:0] root_r, root_nxt;

  // Bit-pair step
  always_comb begin
    rem_sh   = {rem_r[SqrtOutW-1:0], x_r[SqrtInW-1 -: 2]};
    trial    = {root_r, 2'b01};
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {root_r[SqrtOutW-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {root_r[SqrtOutW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CntW'(SqrtOutW);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - CntW'(1);
      done_r <= (cnt_r == CntW'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cnt_r != '0) begin
      x_r    <= {x_r[SqrtInW-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Testbench for the three-axis rate PD controller: table-driven and random steps checked by a predictor.
`timescale 1ns / 1ps
module testbench;
  import tarpd_pkg::*;

  typedef struct {
    logic signed [23:0] rate [3];
    logic signed [23:0] perr [3];
    logic [19:0]        step_us;
    logic               is_first;
  } step_t;

  typedef struct {
    logic [31:0] accel [3];
  } accel_t;

  typedef struct {
    step_t  stim;
    bit     has_exp;
    accel_t exp_val;
  } row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [167:0] in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [95:0]  out_tdata;
  logic         cfg_wr_en = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [23:0]  cfg_wdata = '0;

  // Predictor copy of gains and stored rate errors
  logic [23:0]        kp;
  logic [23:0]        kd;
  logic [22:0]        tgt_mag;
  logic signed [63:0] prev_err [3];

  accel_t accel_q [$];
  int     n_fail = 0;
  bit     stim_done = 0;

  three_axis_rate_pd_controller u_dut (.*);

  always #1 clk = ~clk;

  initial begin
    #50000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] magn(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  // Work out one control step; returns 0 when the step is skipped
  function automatic bit predict_accel(step_t s, output accel_t a);
    logic signed [63:0] r [3];
    logic signed [63:0] des, p, d, res, dms;
    logic [63:0] sum, n, num, pm, am, den, q1, rem, dm;
    sum = 0;
    if (s.step_us == 0) return 0;
    for (int i = 0; i < 3; i++)
      sum += magn(64'(s.perr[i])) * magn(64'(s.perr[i]));
    n = isqrt(sum << 16);
    for (int i = 0; i < 3; i++) begin
      des = 0;
      if (n != 0) begin
        num = 64'(tgt_mag) * magn(64'(s.perr[i])) * 256;
        des = (num + n / 2) / n;
        if (s.perr[i] < 0) des = -des;
      end
      r[i] = 64'(s.rate[i]) + des;
    end
    for (int i = 0; i < 3; i++) begin
      res = 0;
      if (!s.is_first) begin
        pm = (magn(r[i]) * kp + 32768) >> 16;
        p = r[i] < 0 ? -$signed(pm) : $signed(pm);
        d = r[i] - prev_err[i];
        am = magn(d) * kd;
        den = 64'(s.step_us) << 16;
        q1 = am / den;
        rem = am % den;
        if (q1 > (64'd1 << 20)) begin
          dm = 64'd1 << 40;
        end else begin
          dm = q1 * 1000000 + (rem * 1000000 + den / 2) / den;
          if (dm > (64'd1 << 40)) dm = 64'd1 << 40;
        end
        dms = d < 0 ? -$signed(dm) : $signed(dm);
        res = -(p + dms);
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        if (res < -64'sd2147483648) res = -64'sd2147483648;
      end
      a.accel[i] = res[31:0];
    end
    for (int i = 0; i < 3; i++) prev_err[i] = r[i];
    return 1;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_PROP_GAIN:  kp = val;
      REG_DERIV_GAIN: kd = val;
      REG_TGT_MAG:    tgt_mag = val[22:0];
      default: ;
    endcase
  endtask

  // Wait for all results, then let a skipped step settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (accel_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_step(step_t s, bit has_exp, accel_t ev);
    accel_t a;
    int gap;
    gap = $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, s.step_us, s.perr[2], s.perr[1], s.perr[0],
                 s.rate[2], s.rate[1], s.rate[0]};
    in_tuser <= s.is_first;
    do @(posedge clk); while (!in_tready);
    if (predict_accel(s, a)) begin
      if (has_exp) a = ev;
      accel_q.push_back(a);
    end
  endtask

  function automatic logic signed [23:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 24'sh7fffff;
      1: return 24'sh800000;
      2: return 24'($signed($urandom_range(0, 2000)) - 1000);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic step_t rand_step();
    step_t s;
    for (int i = 0; i < 3; i++) begin
      s.rate[i] = rand_val();
      s.perr[i] = ($urandom_range(0, 9) == 0) ? 24'sd0 : rand_val();
    end
    case ($urandom_range(0, 9))
      0: s.step_us = 0;
      1: s.step_us = 20'hfffff;
      2: s.step_us = 20'($urandom);
      default: s.step_us = 20'($urandom_range(1, 20000));
    endcase
    s.is_first = ($urandom_range(0, 9) == 0);
    return s;
  endfunction

  function automatic step_t mk(int r0, int r1, int r2, int e0, int e1, int e2,
                               int dt, bit f);
    step_t s;
    s.rate[0] = 24'(r0); s.rate[1] = 24'(r1); s.rate[2] = 24'(r2);
    s.perr[0] = 24'(e0); s.perr[1] = 24'(e1); s.perr[2] = 24'(e2);
    s.step_us = 20'(dt);
    s.is_first = f;
    return s;
  endfunction

  // Stimulus
  initial begin
    row_t   dir [$];
    row_t   row;
    accel_t zero_acc;
    accel_t sat_pos;
    step_t  s;
    zero_acc.accel = '{0, 0, 0};
    sat_pos.accel = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
    kp = PROP_GAIN_RST;
    kd = DERIV_GAIN_RST;
    tgt_mag = TGT_MAG_RST;
    prev_err = '{0, 0, 0};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: first step, zero step, zero error, extremes
    row = '{mk(0, 0, 0, 0, 0, 0, 1, 1), 1, zero_acc};                 dir.push_back(row);
    row = '{mk(0, 0, 0, 0, 0, 0, 1, 0), 1, zero_acc};                 dir.push_back(row);
    row = '{mk(1000, 2000, 3000, 0, 0, 0, 0, 0), 0, zero_acc};        dir.push_back(row);
    row = '{mk(1000, -2000, 3000, 0, 0, 0, 100, 0), 0, zero_acc};     dir.push_back(row);
    row = '{mk(-8388608, -8388608, -8388608, 0, 0, 0, 1, 0), 1, sat_pos};
    dir.push_back(row);
    row = '{mk(8388607, 8388607, 8388607, 0, 0, 0, 1, 0), 0, zero_acc};
    dir.push_back(row);
    row = '{mk(0, 0, 0, 8388607, 0, 0, 1000, 0), 0, zero_acc};        dir.push_back(row);
    row = '{mk(0, 0, 0, -8388608, -8388608, -8388608, 1000, 0), 0, zero_acc};
    dir.push_back(row);
    row = '{mk(5, -5, 0, 1, -1, 1, 1048575, 0), 0, zero_acc};         dir.push_back(row);
    row = '{mk(500, 600, 700, 3, 4, 0, 1000, 1), 1, zero_acc};        dir.push_back(row);
    row = '{mk(500, 600, 700, 3, 4, 0, 0, 1), 0, zero_acc};           dir.push_back(row);
    row = '{mk(-500, 600, -700, 3, 4, 12, 1000, 0), 0, zero_acc};     dir.push_back(row);
    foreach (dir[k]) send_step(dir[k].stim, dir[k].has_exp, dir[k].exp_val);
    drain();

    // Random phases across several register settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1: begin
          write_reg(REG_PROP_GAIN, 24'hffffff);
          write_reg(REG_DERIV_GAIN, 24'hffffff);
          write_reg(REG_TGT_MAG, 24'h7fffff);
        end
        2: begin
          write_reg(REG_PROP_GAIN, 24'h0);
          write_reg(REG_DERIV_GAIN, 24'h0);
          write_reg(REG_TGT_MAG, 24'h0);
        end
        3: write_reg(2'd3, 24'($urandom));
        4: begin
          write_reg(REG_TGT_MAG, 24'hffffff);
          write_reg(REG_PROP_GAIN, PROP_GAIN_RST);
          write_reg(REG_DERIV_GAIN, DERIV_GAIN_RST);
        end
        default: if (ph > 4) begin
          write_reg(REG_PROP_GAIN, 24'($urandom));
          write_reg(REG_DERIV_GAIN, 24'($urandom_range(0, 200000)));
          write_reg(REG_TGT_MAG, 24'($urandom));
        end
      endcase
      for (int k = 0; k < 100; k++) begin
        s = rand_step();
        send_step(s, 0, zero_acc);
      end
      drain();
    end
    stim_done = 1;
  end

  // Result side: random stalls and checking
  initial begin
    accel_t ev;
    accel_t got;
    int gap;
    @(posedge rst_n);
    forever begin
      gap = $urandom_range(0, 19);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got.accel[0] = out_tdata[31:0];
      got.accel[1] = out_tdata[63:32];
      got.accel[2] = out_tdata[95:64];
      if (accel_q.size() == 0) begin
        $error("unexpected result transfer");
        n_fail++;
      end else begin
        ev = accel_q.pop_front();
        for (int i = 0; i < 3; i++)
          if (got.accel[i] !== ev.accel[i]) begin
            $error("accel[%0d]: expected %0d, got %0d", i,
                   $signed(ev.accel[i]), $signed(got.accel[i]));
            n_fail++;
          end
      end
    end
  end

  // End of run
  initial begin
    wait (stim_done);
    repeat (600) @(posedge clk);
    if (n_fail == 0 && accel_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
